[sv/hrmc_pkg.sv]
// Shared types and constants for the HSV range mask centroid block.
package hrmc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int CH_W       = 8;
    localparam int SIZE_W     = 11;
    localparam int CEN_W      = 10;
    localparam int CNT_OUT_W  = 21;

    localparam logic [CFG_IDX_W-1:0] REG_HUE_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HUE_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_LOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_HIGH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VAL_LOW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VAL_HIGH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 3'd7;

    localparam logic [CH_W-1:0]   RST_HUE_LOW    = 8'd39;
    localparam logic [CH_W-1:0]   RST_HUE_HIGH   = 8'd45;
    localparam logic [CH_W-1:0]   RST_SAT_LOW    = 8'd220;
    localparam logic [CH_W-1:0]   RST_SAT_HIGH   = 8'd255;
    localparam logic [CH_W-1:0]   RST_VAL_LOW    = 8'd220;
    localparam logic [CH_W-1:0]   RST_VAL_HIGH   = 8'd255;
    localparam logic [SIZE_W-1:0] RST_FRAME_COLS = 11'd320;
    localparam logic [SIZE_W-1:0] RST_FRAME_ROWS = 11'd240;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_COL  = 4'b0010,
        S_ROW  = 4'b0100,
        S_WAIT = 4'b1000
    } t_state;

    typedef struct packed {
        logic pix;
        logic snap;
        logic step;
        logic init_row;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic last_pix;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

[sv/hrmc_if.sv]
// Pixel and result channel interfaces.
interface hrmc_pix_if import hrmc_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] hue;
    logic [CH_W-1:0] sat;
    logic [CH_W-1:0] val;

    modport source (output valid, output hue, output sat, output val, input ready);
    modport sink   (input valid, input hue, input sat, input val, output ready);
endinterface

interface hrmc_res_if import hrmc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CEN_W-1:0]     centroid_col;
    logic [CEN_W-1:0]     centroid_row;
    logic [CNT_OUT_W-1:0] marked_count;

    modport source (output valid, output centroid_col, output centroid_row,
                    output marked_count, input ready);
    modport sink   (input valid, input centroid_col, input centroid_row,
                    input marked_count, output ready);
endinterface

[sv/hrmc_ctrl.sv]
// Sequencer for pixel intake, the shared divider and the result register.
module hrmc_ctrl import hrmc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_pix_valid,
    output logic o_pix_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_fire;

    assign o_pix_ready = !i_sts.last_pix || (r_state == S_IDLE);
    assign w_fire      = i_pix_valid && o_pix_ready;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.pix      = w_fire;
        case (r_state)
            S_IDLE: begin
                if (w_fire && i_sts.last_pix) begin
                    o_cmd.snap = 1'b1;
                    n_state    = S_COL;
                end
            end
            S_COL: begin
                o_cmd.step = 1'b1;
                if (i_sts.div_last) begin
                    o_cmd.init_row = 1'b1;
                    n_state        = S_ROW;
                end
            end
            S_ROW: begin
                o_cmd.step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[sv/hrmc_dp.sv]
// Datapath: bounds, raster counters, accumulators, divider and result register.
module hrmc_dp import hrmc_pkg::*; #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [CH_W-1:0]       i_hue,
    input  logic [CH_W-1:0]       i_sat,
    input  logic [CH_W-1:0]       i_val,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [CEN_W-1:0]      o_centroid_col,
    output logic [CEN_W-1:0]      o_centroid_row,
    output logic [CNT_OUT_W-1:0]  o_marked_count
);

    localparam int CW   = $clog2(MAX_COLS);
    localparam int RW   = $clog2(MAX_ROWS);
    localparam int QW   = (CW > RW) ? CW : RW;
    localparam int NW   = $clog2(MAX_COLS * MAX_ROWS + 1);
    localparam int SUMW = NW + QW;
    localparam int ECW  = (CW + 1 > SIZE_W) ? CW + 1 : SIZE_W;
    localparam int ERW  = (RW + 1 > SIZE_W) ? RW + 1 : SIZE_W;
    localparam int ITW  = $clog2(QW + 1);

    logic [CH_W-1:0]   r_hue_low, r_hue_high, r_sat_low, r_sat_high, r_val_low, r_val_high;
    logic [SIZE_W-1:0] r_frame_cols, r_frame_rows;

    logic [CW-1:0]   r_col;
    logic [RW-1:0]   r_row;
    logic [SUMW-1:0] r_csum, r_rsum;
    logic [NW-1:0]   r_cnt;

    logic [NW-1:0]   r_p;
    logic [QW-1:0]   r_nlo;
    logic [QW-1:0]   r_qcol;
    logic [SUMW-1:0] r_rsnap;
    logic [NW-1:0]   r_den;
    logic [ITW-1:0]  r_it;

    logic                 r_out_valid;
    logic [CEN_W-1:0]     r_out_col, r_out_row;
    logic [CNT_OUT_W-1:0] r_out_cnt;

    logic [ECW-1:0]  w_cols_ext, w_eff_cols;
    logic [ERW-1:0]  w_rows_ext, w_eff_rows;
    logic            w_last_col, w_last_row, w_hit;
    logic [SUMW-1:0] n_csum, n_rsum;
    logic [NW-1:0]   n_cnt;
    logic [NW:0]     w_shift, w_diff;
    logic            w_ge;
    logic [NW-1:0]   n_p;
    logic [QW-1:0]   n_nlo;

    always_comb begin
        w_cols_ext = ECW'(r_frame_cols);
        w_rows_ext = ERW'(r_frame_rows);
        if (w_cols_ext == '0) begin
            w_eff_cols = ECW'(1);
        end else if (w_cols_ext > ECW'(MAX_COLS)) begin
            w_eff_cols = ECW'(MAX_COLS);
        end else begin
            w_eff_cols = w_cols_ext;
        end
        if (w_rows_ext == '0) begin
            w_eff_rows = ERW'(1);
        end else if (w_rows_ext > ERW'(MAX_ROWS)) begin
            w_eff_rows = ERW'(MAX_ROWS);
        end else begin
            w_eff_rows = w_rows_ext;
        end
    end

    assign w_last_col = (ECW'(r_col) + ECW'(1)) >= w_eff_cols;
    assign w_last_row = (ERW'(r_row) + ERW'(1)) >= w_eff_rows;
    assign w_hit = (i_hue >= r_hue_low) && (i_hue <= r_hue_high) &&
                   (i_sat >= r_sat_low) && (i_sat <= r_sat_high) &&
                   (i_val >= r_val_low) && (i_val <= r_val_high);

    assign n_csum = w_hit ? r_csum + SUMW'(r_col) : r_csum;
    assign n_rsum = w_hit ? r_rsum + SUMW'(r_row) : r_rsum;
    assign n_cnt  = r_cnt + NW'(w_hit);

    assign w_shift = {r_p, r_nlo[QW-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_ge    = w_shift >= {1'b0, r_den};
    assign n_p     = w_ge ? w_diff[NW-1:0] : w_shift[NW-1:0];
    assign n_nlo   = QW'({r_nlo, w_ge});

    assign o_sts.last_pix = w_last_col && w_last_row;
    assign o_sts.div_last = r_it == ITW'(QW - 1);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_low    <= RST_HUE_LOW;
            r_hue_high   <= RST_HUE_HIGH;
            r_sat_low    <= RST_SAT_LOW;
            r_sat_high   <= RST_SAT_HIGH;
            r_val_low    <= RST_VAL_LOW;
            r_val_high   <= RST_VAL_HIGH;
            r_frame_cols <= RST_FRAME_COLS;
            r_frame_rows <= RST_FRAME_ROWS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_HUE_LOW:    r_hue_low    <= i_cfg_data[CH_W-1:0];
                REG_HUE_HIGH:   r_hue_high   <= i_cfg_data[CH_W-1:0];
                REG_SAT_LOW:    r_sat_low    <= i_cfg_data[CH_W-1:0];
                REG_SAT_HIGH:   r_sat_high   <= i_cfg_data[CH_W-1:0];
                REG_VAL_LOW:    r_val_low    <= i_cfg_data[CH_W-1:0];
                REG_VAL_HIGH:   r_val_high   <= i_cfg_data[CH_W-1:0];
                REG_FRAME_COLS: r_frame_cols <= i_cfg_data;
                REG_FRAME_ROWS: r_frame_rows <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_csum <= '0;
            r_rsum <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.pix) begin
            r_col <= w_last_col ? '0 : r_col + CW'(1);
            if (w_last_col) begin
                r_row <= w_last_row ? '0 : r_row + RW'(1);
            end
            if (w_last_col && w_last_row) begin
                r_csum <= '0;
                r_rsum <= '0;
                r_cnt  <= '0;
            end else begin
                r_csum <= n_csum;
                r_rsum <= n_rsum;
                r_cnt  <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.snap) begin
            r_p     <= n_csum[SUMW-1:QW];
            r_nlo   <= n_csum[QW-1:0];
            r_rsnap <= n_rsum;
            r_den   <= n_cnt;
        end else if (i_cmd.init_row) begin
            r_qcol <= n_nlo;
            r_p    <= r_rsnap[SUMW-1:QW];
            r_nlo  <= r_rsnap[QW-1:0];
        end else if (i_cmd.step) begin
            r_p   <= n_p;
            r_nlo <= n_nlo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_it <= '0;
        end else if (i_cmd.snap || i_cmd.init_row) begin
            r_it <= '0;
        end else if (i_cmd.step) begin
            r_it <= r_it + ITW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_col <= (r_den == '0) ? '0 : CEN_W'(r_qcol);
            r_out_row <= (r_den == '0) ? '0 : CEN_W'(r_nlo);
            r_out_cnt <= CNT_OUT_W'(r_den);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_centroid_col = r_out_col;
    assign o_centroid_row = r_out_row;
    assign o_marked_count = r_out_cnt;

endmodule

[sv/hsv_range_mask_centroid_top.sv]
// Top level of the HSV range mask centroid block.
//
// Pixels enter on i_pix (hue, sat, val) in raster order, one word per clock while i_pix.ready is high.
// Each pixel inside all three inclusive bands is counted and its column and
// row are summed. After the last pixel of a frame (frame_cols x frame_rows,
// a size of 0 acting as 1 and a size above MAX_COLS/MAX_ROWS acting as that
// limit) one word leaves on o_res: truncated mean column, mean row and count,
// with (0,0) when no pixel matched.
// After the last pixel, Q = ceil(log2(max(MAX_COLS, MAX_ROWS))) quotient bits
// are made by one restoring divider that produces one quotient bit per cycle
// for the column, then for the row, before o_res is loaded.
// Throughput: one pixel per clock; the division runs during the next frame.
// i_pix.ready drops only on the final pixel of a frame while the previous frame
// is still being divided or its result still waits for o_res.
// Reset restores the register defaults, clears counters and sums and drops
// o_res.valid. A stalled o_res holds its word; the divider waits for it while
// pixels of the next frame keep flowing. The user must write registers through
// i_cfg_we/i_cfg_idx/i_cfg_data only while idle; the block does not enforce it.
module hsv_range_mask_centroid_top import hrmc_pkg::*; #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    hrmc_pix_if.sink              i_pix,
    hrmc_res_if.source            o_res
);

    t_cmd w_cmd;
    t_sts w_sts;

    hrmc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (i_pix.valid),
        .o_pix_ready (i_pix.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    hrmc_dp #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_hue          (i_pix.hue),
        .i_sat          (i_pix.sat),
        .i_val          (i_pix.val),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_out_valid    (o_res.valid),
        .i_out_ready    (o_res.ready),
        .o_centroid_col (o_res.centroid_col),
        .o_centroid_row (o_res.centroid_row),
        .o_marked_count (o_res.marked_count)
    );

endmodule

[sv/hrmc_chk.sv]
// Port-level assertions for the HSV range mask centroid block, with bind.
module hrmc_chk import hrmc_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_pix_valid,
    input logic                 i_pix_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [CEN_W-1:0]     i_col,
    input logic [CEN_W-1:0]     i_row,
    input logic [CNT_OUT_W-1:0] i_cnt
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_col) && $stable(i_row) && $stable(i_cnt))
        else $error("result word changed while stalled");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid ##1 !i_out_valid)
        else $error("result word soon after reset");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_cnt == '0) |-> (i_col == '0) && (i_row == '0))
        else $error("nonzero centroid with no marked pixel");

    a_ready_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix_valid |-> !$isunknown(i_pix_ready))
        else $error("pixel ready unknown while a word is offered");

endmodule

bind hsv_range_mask_centroid_top hrmc_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_pix_valid (i_pix.valid),
    .i_pix_ready (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_col       (o_res.centroid_col),
    .i_row       (o_res.centroid_row),
    .i_cnt       (o_res.marked_count)
);

[tb/sv/hsv_range_mask_centroid_checker.sv]
`timescale 1ns / 100ps
// Checker: tracks config and pixel words, predicts each frame's centroid and compares it.
module hsv_range_mask_centroid_checker import hrmc_pkg::*; #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    hrmc_pix_if                   pix,
    hrmc_res_if                   res,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic [CEN_W-1:0]     col;
        logic [CEN_W-1:0]     row;
        logic [CNT_OUT_W-1:0] count;
    } t_centroid;

    logic [CH_W-1:0]      hue_lo, hue_hi, sat_lo, sat_hi, val_lo, val_hi;
    logic [SIZE_W-1:0]    cols_reg, rows_reg;
    logic [SIZE_W-1:0]    col_pos, row_pos;
    logic [29:0]          col_sum, row_sum;
    logic [CNT_OUT_W-1:0] hits;
    t_centroid            centroid_q[$];
    int                   fails = 0;

    function automatic int unsigned eff_len(int unsigned v, int unsigned limit);
        if (v == 0) return 1;
        if (v > limit) return limit;
        return v;
    endfunction

    function automatic logic in_band(logic [CH_W-1:0] x, logic [CH_W-1:0] lo,
                                     logic [CH_W-1:0] hi);
        return (x >= lo) && (x <= hi);
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_centroid   want;
        int unsigned n_cols, n_rows;
        if (!i_rst_n) begin
            hue_lo   = RST_HUE_LOW;
            hue_hi   = RST_HUE_HIGH;
            sat_lo   = RST_SAT_LOW;
            sat_hi   = RST_SAT_HIGH;
            val_lo   = RST_VAL_LOW;
            val_hi   = RST_VAL_HIGH;
            cols_reg = RST_FRAME_COLS;
            rows_reg = RST_FRAME_ROWS;
            col_pos  = '0;
            row_pos  = '0;
            col_sum  = '0;
            row_sum  = '0;
            hits     = '0;
            centroid_q.delete();
        end else begin
            if (res.valid && res.ready) begin
                if (centroid_q.size() == 0) begin
                    $error("result word with no frame pending: col %0d row %0d count %0d",
                           res.centroid_col, res.centroid_row, res.marked_count);
                    fails++;
                end else begin
                    want = centroid_q.pop_front();
                    check_field("centroid_col", want.col, res.centroid_col);
                    check_field("centroid_row", want.row, res.centroid_row);
                    check_field("marked_count", want.count, res.marked_count);
                end
            end
            if (pix.valid && pix.ready) begin
                n_cols = eff_len(cols_reg, MAX_COLS);
                n_rows = eff_len(rows_reg, MAX_ROWS);
                if (in_band(pix.hue, hue_lo, hue_hi) && in_band(pix.sat, sat_lo, sat_hi) &&
                    in_band(pix.val, val_lo, val_hi)) begin
                    col_sum = col_sum + col_pos;
                    row_sum = row_sum + row_pos;
                    hits    = hits + 1'b1;
                end
                if (col_pos + 1 < n_cols) begin
                    col_pos = col_pos + 1'b1;
                end else begin
                    col_pos = '0;
                    if (row_pos + 1 < n_rows) begin
                        row_pos = row_pos + 1'b1;
                    end else begin
                        want.col   = '0;
                        want.row   = '0;
                        want.count = hits;
                        if (hits != 0) begin
                            want.col = CEN_W'(col_sum / 30'(hits));
                            want.row = CEN_W'(row_sum / 30'(hits));
                        end
                        centroid_q.push_back(want);
                        row_pos = '0;
                        col_sum = '0;
                        row_sum = '0;
                        hits    = '0;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_HUE_LOW:    hue_lo   = i_cfg_data[CH_W-1:0];
                    REG_HUE_HIGH:   hue_hi   = i_cfg_data[CH_W-1:0];
                    REG_SAT_LOW:    sat_lo   = i_cfg_data[CH_W-1:0];
                    REG_SAT_HIGH:   sat_hi   = i_cfg_data[CH_W-1:0];
                    REG_VAL_LOW:    val_lo   = i_cfg_data[CH_W-1:0];
                    REG_VAL_HIGH:   val_hi   = i_cfg_data[CH_W-1:0];
                    REG_FRAME_COLS: cols_reg = i_cfg_data[SIZE_W-1:0];
                    REG_FRAME_ROWS: rows_reg = i_cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end
        end
        o_fail_count <= fails;
        o_pending    <= centroid_q.size();
    end

endmodule

[tb/sv/hsv_range_mask_centroid_top_test.sv]
`timescale 1ns / 100ps
// Testbench top: drives pixel frames and register settings into the centroid block.
module hsv_range_mask_centroid_top_test;
    import hrmc_pkg::*;

    localparam int MAX_COLS     = 1024;
    localparam int MAX_ROWS     = 1024;
    localparam int DIV_LATENCY  = 2 * 10 + 1;
    localparam int DRAIN_CYCLES = DIV_LATENCY + 16;
    localparam int RANDOM_ITEMS = 550;

    localparam logic [CFG_IDX_W-1:0] LOW_IDX  [3] = '{REG_HUE_LOW, REG_SAT_LOW, REG_VAL_LOW};
    localparam logic [CFG_IDX_W-1:0] HIGH_IDX [3] = '{REG_HUE_HIGH, REG_SAT_HIGH, REG_VAL_HIGH};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    fail_count;
    int                    pending;
    int                    burst_left = 0;
    logic [CH_W-1:0]       band_lo [3];
    logic [CH_W-1:0]       band_hi [3];

    hrmc_pix_if pix_if ();
    hrmc_res_if res_if ();

    hsv_range_mask_centroid_top #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_if),
        .o_res      (res_if)
    );

    hsv_range_mask_centroid_checker #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .pix          (pix_if),
        .res          (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #6 i_clk = ~i_clk;

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic set_band(input int ch, input logic [CH_W-1:0] lo, input logic [CH_W-1:0] hi);
        write_reg(LOW_IDX[ch], {(CFG_DATA_W-CH_W)'($urandom), lo});
        write_reg(HIGH_IDX[ch], {(CFG_DATA_W-CH_W)'($urandom), hi});
        band_lo[ch] = lo;
        band_hi[ch] = hi;
    endtask

    task automatic set_frame(input logic [SIZE_W-1:0] cols, input logic [SIZE_W-1:0] rows);
        write_reg(REG_FRAME_COLS, cols);
        write_reg(REG_FRAME_ROWS, rows);
    endtask

    // hold off until every frame result is out and the divider has gone quiet
    task automatic drain();
        pix_if.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_pixel(input logic [CH_W-1:0] h, input logic [CH_W-1:0] s,
                              input logic [CH_W-1:0] v);
        int gap;
        i_cfg_we <= 1'b0;
        if (burst_left == 0) begin
            gap = ($urandom_range(4) == 0) ? 0 : $urandom_range(6, 1);
            if (gap != 0) begin
                pix_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(7) == 0) ? 64 : $urandom_range(16, 1);
        end
        pix_if.valid <= 1'b1;
        pix_if.hue   <= h;
        pix_if.sat   <= s;
        pix_if.val   <= v;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        burst_left--;
    endtask

    function automatic logic [CH_W-1:0] pick_chan(input int ch);
        logic [CH_W-1:0] lo, hi;
        lo = band_lo[ch];
        hi = band_hi[ch];
        if (lo <= hi && $urandom_range(3) != 0) begin
            case ($urandom_range(5))
                0:       return lo;
                1:       return hi;
                default: return CH_W'($urandom_range(hi, lo));
            endcase
        end
        case ($urandom_range(3))
            0:       return lo - 1'b1;
            1:       return hi + 1'b1;
            default: return CH_W'($urandom_range(255, 0));
        endcase
    endfunction

    task automatic send_random(input int n);
        repeat (n) send_pixel(pick_chan(0), pick_chan(1), pick_chan(2));
    endtask

    task automatic random_band(input int ch);
        logic [CH_W-1:0] a, b;
        case ($urandom_range(7))
            0: begin
                a = CH_W'($urandom_range(255, 1));
                b = CH_W'($urandom_range(a - 1, 0));
                set_band(ch, a, b);
            end
            1: set_band(ch, 8'd0, 8'd255);
            2: begin
                a = CH_W'($urandom_range(255, 0));
                set_band(ch, a, a);
            end
            default: begin
                a = CH_W'($urandom_range(255, 0));
                b = CH_W'($urandom_range(255, 0));
                if (a <= b) set_band(ch, a, b);
                else set_band(ch, b, a);
            end
        endcase
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(7))
            0:       return '0;
            1:       return SIZE_W'(1);
            default: return SIZE_W'($urandom_range(5, 2));
        endcase
    endfunction

    initial begin
        res_if.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            int on_len, off_len;
            on_len  = ($urandom_range(7) == 0) ? 80 : $urandom_range(20, 1);
            off_len = $urandom_range(12, 0);
            res_if.ready <= 1'b1;
            repeat (on_len) @(posedge i_clk);
            if (off_len != 0) begin
                res_if.ready <= 1'b0;
                repeat (off_len) @(posedge i_clk);
            end
        end
    end

    initial begin
        #8000000;
        $display("hsv_range_mask_centroid_top test failed");
        $finish;
    end

    initial begin
        int phase, rand_items, n;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        pix_if.valid = 1'b0;
        pix_if.hue   = '0;
        pix_if.sat   = '0;
        pix_if.val   = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full bands, extreme channel values, 3x2 frame
        set_band(0, 8'd0, 8'd255);
        set_band(1, 8'd0, 8'd255);
        set_band(2, 8'd0, 8'd255);
        set_frame(11'd3, 11'd2);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'h55, 8'hAA, 8'h55);
        send_pixel(8'hAA, 8'h55, 8'hAA);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd255, 8'd0, 8'd255);
        drain();

        // band edges, zero column count acting as one
        set_band(0, 8'd40, 8'd45);
        set_band(1, 8'd220, 8'd254);
        set_band(2, 8'd1, 8'd250);
        set_frame(11'd0, 11'd4);
        send_pixel(8'd40, 8'd220, 8'd1);
        send_pixel(8'd39, 8'd220, 8'd1);
        send_pixel(8'd45, 8'd254, 8'd250);
        send_pixel(8'd46, 8'd254, 8'd250);
        send_pixel(8'd40, 8'd219, 8'd1);
        send_pixel(8'd40, 8'd255, 8'd1);
        send_pixel(8'd40, 8'd220, 8'd0);
        send_pixel(8'd40, 8'd220, 8'd251);
        drain();

        // empty hue band
        set_band(0, 8'd100, 8'd99);
        set_frame(11'd2, 11'd1);
        send_pixel(8'd100, 8'd230, 8'd100);
        send_pixel(8'd99, 8'd230, 8'd100);
        drain();

        // shrink the frame while counters sit past the new last position
        set_band(0, 8'd0, 8'd255);
        set_frame(11'd4, 11'd3);
        send_random(6);
        drain();
        set_frame(11'd2, 11'd1);
        send_pixel(8'd128, 8'd230, 8'd128);

        rand_items = 0;
        phase      = 0;
        while (rand_items < RANDOM_ITEMS) begin
            drain();
            if (phase == 4 || phase == 9) begin
                random_band(1);
                random_band(2);
                if (phase == 4) set_frame(11'd2047, 11'd1);
                else set_frame(11'd1, 11'd1024);
                n = $urandom_range(80, 20);
                send_random(n);
                rand_items += n;
            end else begin
                for (int ch = 0; ch < 3; ch++) begin
                    if ($urandom_range(3) != 0) random_band(ch);
                end
                if ($urandom_range(1) != 0) write_reg(REG_FRAME_COLS, pick_size());
                if ($urandom_range(1) != 0) write_reg(REG_FRAME_ROWS, pick_size());
                n = $urandom_range(40, 1);
                send_random(n);
                rand_items += n;
            end
            phase++;
        end

        drain();
        if (fail_count == 0) begin
            $display("hsv_range_mask_centroid_top test passed");
        end else begin
            $display("hsv_range_mask_centroid_top test failed");
        end
        $finish;
    end

endmodule

[hsv_range_mask_centroid_top.f]
sv/hrmc_pkg.sv
sv/hrmc_if.sv
sv/hrmc_ctrl.sv
sv/hrmc_dp.sv
sv/hsv_range_mask_centroid_top.sv
sv/hrmc_chk.sv
tb/sv/hsv_range_mask_centroid_checker.sv
tb/sv/hsv_range_mask_centroid_top_test.sv
